// ===== sv/delta_modulation_sample_channel_core_assert.svh =====
// assertion macros used by the port-level checker of the sample channel
`ifndef DELTA_MODULATION_SAMPLE_CHANNEL_CORE_ASSERT_SVH
`define DELTA_MODULATION_SAMPLE_CHANNEL_CORE_ASSERT_SVH

// property checked only while out of reset
`define DMC_ASSERT_ACTIVE(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define DMC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/dmc_pkg.sv =====
// types, constants and the rate table of the delta-modulation sample channel
package dmc_pkg;

    // item kind carried in tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register selects
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_LEVEL   = 3'd1;
    localparam logic [2:0] REG_START   = 3'd2;
    localparam logic [2:0] REG_LENGTH  = 3'd3;
    localparam logic [2:0] REG_ENABLE  = 3'd4;

    // address and level constants
    localparam logic [15:0] START_BASE    = 16'hC000;
    localparam logic [15:0] WRAP_ADDR     = 16'h8000;
    localparam logic [15:0] ADDR_MAX      = 16'hFFFF;
    localparam logic [5:0]  LEVEL_MAX     = 6'h3F;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LOOP   = 2'd1,
        MODE_IRQ    = 2'd2
    } play_mode_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] fetch_data;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  sample_value;
        logic        irq_flag;
        logic [15:0] fetch_address;
        logic        byte_taken;
        logic [11:0] rate_period;
        logic [11:0] bytes_remaining;
    } result_t;

    // timer period for each rate index
    function automatic logic [11:0] rate_lookup(input logic [3:0] idx);
        logic [11:0] p;
        unique case (idx)
            4'd0:    p = 12'hD60;
            4'd1:    p = 12'hBE0;
            4'd2:    p = 12'hAA0;
            4'd3:    p = 12'hA00;
            4'd4:    p = 12'h8F0;
            4'd5:    p = 12'h7F0;
            4'd6:    p = 12'h710;
            4'd7:    p = 12'h6B0;
            4'd8:    p = 12'h5F0;
            4'd9:    p = 12'h500;
            4'd10:   p = 12'h470;
            4'd11:   p = 12'h400;
            4'd12:   p = 12'h350;
            4'd13:   p = 12'h2A0;
            4'd14:   p = 12'h240;
            default: p = 12'h1B0;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/dmc_channel.sv =====
// channel state registers and the single-pass update for one item
module dmc_channel (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dmc_pkg::in_item_t item,
    output dmc_pkg::result_t  result
);

    logic                has_sample_reg, has_sample_next;
    dmc_pkg::play_mode_t play_mode_reg, play_mode_next;
    logic [11:0]         period_reg, period_next;
    logic [3:0]          bit_count_reg, bit_count_next;
    logic [5:0]          delta_level_reg, delta_level_next;
    logic                level_lsb_reg, level_lsb_next;
    logic [7:0]          shift_reg, shift_next;
    logic [15:0]         start_addr_reg, start_addr_next;
    logic [15:0]         play_addr_reg, play_addr_next;
    logic [11:0]         length_reg, length_next;
    logic [11:0]         bytes_left_reg, bytes_left_next;
    logic                irq_reg, irq_next;
    logic                enabled_reg, enabled_next;
    logic [6:0]          out_level_reg, out_level_next;
    logic                taken;
    logic [7:0]          d;

    assign d = item.write_data;

    // next state for a register write or a rate tick
    always_comb
    begin
        has_sample_next  = has_sample_reg;
        play_mode_next   = play_mode_reg;
        period_next      = period_reg;
        bit_count_next   = bit_count_reg;
        delta_level_next = delta_level_reg;
        level_lsb_next   = level_lsb_reg;
        shift_next       = shift_reg;
        start_addr_next  = start_addr_reg;
        play_addr_next   = play_addr_reg;
        length_next      = length_reg;
        bytes_left_next  = bytes_left_reg;
        irq_next         = irq_reg;
        enabled_next     = enabled_reg;
        out_level_next   = out_level_reg;
        taken            = 1'b0;

        if (item.mode == dmc_pkg::KIND_WRITE)
        begin
            unique case (item.reg_select)
                dmc_pkg::REG_CONTROL:
                begin
                    // loop bit wins over irq bit
                    if (d[6])
                        play_mode_next = dmc_pkg::MODE_LOOP;
                    else if (d[7])
                        play_mode_next = dmc_pkg::MODE_IRQ;
                    else
                        play_mode_next = dmc_pkg::MODE_NORMAL;
                    if (!d[7])
                        irq_next = 1'b0;
                    period_next = dmc_pkg::rate_lookup(d[3:0]);
                end
                dmc_pkg::REG_LEVEL:
                begin
                    delta_level_next = d[6:1];
                    level_lsb_next   = d[0];
                    out_level_next   = d[6:0];
                end
                dmc_pkg::REG_START:
                begin
                    start_addr_next = dmc_pkg::START_BASE | {2'b00, d, 6'b000000};
                    play_addr_next  = dmc_pkg::START_BASE | {2'b00, d, 6'b000000};
                end
                dmc_pkg::REG_LENGTH:
                begin
                    length_next     = {d, 4'b0000} + 12'd1;
                    bytes_left_next = {d, 4'b0000} + 12'd1;
                end
                dmc_pkg::REG_ENABLE:
                begin
                    if (d[4])
                    begin
                        enabled_next    = 1'b1;
                        play_addr_next  = start_addr_reg;
                        bytes_left_next = length_reg;
                    end
                    else
                    begin
                        enabled_next    = 1'b0;
                        bytes_left_next = 12'd0;
                    end
                    irq_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // move the level by the low bit of the held byte
            if (has_sample_reg)
            begin
                if (shift_reg[0])
                begin
                    if (delta_level_reg < dmc_pkg::LEVEL_MAX)
                        delta_level_next = delta_level_reg + 6'd1;
                end
                else if (delta_level_reg != 6'd0)
                begin
                    delta_level_next = delta_level_reg - 6'd1;
                end
                out_level_next = enabled_reg ? {delta_level_next, level_lsb_reg} : 7'd0;
                shift_next     = {1'b0, shift_reg[7:1]};
            end

            // byte boundary: reload, loop and fetch
            if (bit_count_reg <= 4'd1)
            begin
                has_sample_next = 1'b0;
                bit_count_next  = dmc_pkg::BITS_PER_BYTE;
                if (bytes_left_reg == 12'd0 && play_mode_reg == dmc_pkg::MODE_LOOP)
                begin
                    play_addr_next  = start_addr_reg;
                    bytes_left_next = length_reg;
                end
                if (bytes_left_next != 12'd0)
                begin
                    shift_next      = item.fetch_data;
                    bytes_left_next = bytes_left_next - 12'd1;
                    play_addr_next  = (play_addr_next == dmc_pkg::ADDR_MAX)
                                      ? dmc_pkg::WRAP_ADDR : play_addr_next + 16'd1;
                    has_sample_next = 1'b1;
                    taken           = 1'b1;
                    if (bytes_left_next == 12'd0 && play_mode_reg == dmc_pkg::MODE_IRQ)
                        irq_next = 1'b1;
                end
            end
            else
            begin
                bit_count_next = bit_count_reg - 4'd1;
            end
        end
    end

    // result fields from the updated state
    always_comb
    begin
        result.sample_value    = out_level_next;
        result.irq_flag        = irq_next;
        result.fetch_address   = play_addr_next;
        result.byte_taken      = taken;
        result.rate_period     = period_next;
        result.bytes_remaining = bytes_left_next;
    end

    // state update on each item that moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_sample_reg  <= 1'b0;
            play_mode_reg   <= dmc_pkg::MODE_NORMAL;
            period_reg      <= 12'd0;
            bit_count_reg   <= 4'd0;
            delta_level_reg <= 6'd0;
            level_lsb_reg   <= 1'b0;
            shift_reg       <= 8'd0;
            start_addr_reg  <= 16'd0;
            play_addr_reg   <= 16'd0;
            length_reg      <= 12'd0;
            bytes_left_reg  <= 12'd0;
            irq_reg         <= 1'b0;
            enabled_reg     <= 1'b0;
            out_level_reg   <= 7'd0;
        end
        else if (advance)
        begin
            has_sample_reg  <= has_sample_next;
            play_mode_reg   <= play_mode_next;
            period_reg      <= period_next;
            bit_count_reg   <= bit_count_next;
            delta_level_reg <= delta_level_next;
            level_lsb_reg   <= level_lsb_next;
            shift_reg       <= shift_next;
            start_addr_reg  <= start_addr_next;
            play_addr_reg   <= play_addr_next;
            length_reg      <= length_next;
            bytes_left_reg  <= bytes_left_next;
            irq_reg         <= irq_next;
            enabled_reg     <= enabled_next;
            out_level_reg   <= out_level_next;
        end
    end

endmodule

// ===== sv/delta_modulation_sample_channel_core.sv =====
// top level of the delta-modulation sample channel
//
// Usage:
// - s_axis carries one item per transfer: tuser = 0 for a rate tick,
//   1 for a register write; tdata holds reg_select, write_data and the
//   memory byte at the fetch address last reported.
// - m_axis returns exactly one result per input item, in order: output
//   level, irq flag, next fetch address, byte-taken flag, timer period
//   and bytes left.
// - An input transfer is held in the input register, and its state update
//   lands in the result register when it advances, making the result valid.
// - Throughput is one item per cycle while the receiver keeps up; the
//   input register and the result register each hold one item, so a new
//   item is taken while a finished result waits.
// - When the receiver stalls, the result holds and the input register
//   fills; s_axis_tready drops once both are occupied and rises in the
//   cycle the result is taken.
// - Reset clears both valid flags and returns all channel state to zero,
//   normal mode, disabled.
module delta_modulation_sample_channel_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] reg_select, [10:3] write_data, [18:11] fetch_data, [23:19] zero
    input  logic [dmc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] sample_value, [7] irq_flag, [23:8] fetch_address, [24] byte_taken,
    // [36:25] rate_period, [48:37] bytes_remaining, [55:49] zero
    output logic [dmc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg;
    dmc_pkg::in_item_t in_item_reg;
    logic              out_valid_reg;
    dmc_pkg::result_t  out_result_reg;
    dmc_pkg::result_t  result;
    logic              advance;

    // item moves on when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.mode       <= s_axis_tuser;
            in_item_reg.reg_select <= s_axis_tdata[2:0];
            in_item_reg.write_data <= s_axis_tdata[10:3];
            in_item_reg.fetch_data <= s_axis_tdata[18:11];
        end
    end

    dmc_channel u_channel (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_result_reg.bytes_remaining,
                            out_result_reg.rate_period,
                            out_result_reg.byte_taken,
                            out_result_reg.fetch_address,
                            out_result_reg.irq_flag,
                            out_result_reg.sample_value};

endmodule

// ===== sv/dmc_checker.sv =====
// port-level checker for the sample channel and its bind
`include "delta_modulation_sample_channel_core_assert.svh"

module dmc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [dmc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result stays in place
    `DMC_ASSERT_ACTIVE(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")

    // the input only stalls behind a stalled result
    `DMC_ASSERT_ACTIVE(a_in_stall, clk, rst_n,
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready,
        "input stalled with no stalled result")

    // bytes left never exceed the longest sample
    `DMC_ASSERT_ACTIVE(a_bytes_bound, clk, rst_n,
        m_axis_tvalid |-> m_axis_tdata[48:37] <= 12'd4081, "bytes left out of range")

    // pad bits of the result stay zero
    `DMC_ASSERT_ACTIVE(a_pad_zero, clk, rst_n,
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0, "result pad bits set")

    // no result shown while in reset
    `DMC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind delta_modulation_sample_channel_core dmc_checker u_dmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/delta_modulation_sample_channel_core_checker.sv =====
`timescale 1ns / 1ps
// checker that predicts each result of the sample channel and compares it on transfer
module delta_modulation_sample_channel_core_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [2:0] reg_select, [10:3] write_data, [18:11] fetch_data, [23:19] zero
    input  logic [dmc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] sample_value, [7] irq_flag, [23:8] fetch_address, [24] byte_taken,
    // [36:25] rate_period, [48:37] bytes_remaining, [55:49] zero
    input  logic [dmc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             mismatch_count,
    output int                             outstanding
);

    // timer period per rate index, index 0 leftmost
    localparam logic [0:15][11:0] RATE_PERIODS = {
        12'hD60, 12'hBE0, 12'hAA0, 12'hA00, 12'h8F0, 12'h7F0, 12'h710, 12'h6B0,
        12'h5F0, 12'h500, 12'h470, 12'h400, 12'h350, 12'h2A0, 12'h240, 12'h1B0
    };

    // predicted channel state
    logic                holding_byte;
    dmc_pkg::play_mode_t play_mode_now;
    logic [11:0]         timer_period;
    logic [3:0]          bits_to_go;
    logic [5:0]          level6;
    logic                level_lsb_bit;
    logic [7:0]          shift_reg;
    logic [15:0]         start_addr;
    logic [15:0]         next_addr;
    logic [11:0]         length_bytes;
    logic [11:0]         bytes_left_now;
    logic                irq_now;
    logic                enabled_now;
    logic [6:0]          level_out;

    // results still owed by the block, oldest first
    dmc_pkg::result_t expected_results[$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // advance the predicted channel by one item and return its result
    function automatic dmc_pkg::result_t predict_step(input dmc_pkg::in_item_t item);
        dmc_pkg::result_t r;
        logic             took;
        took = 1'b0;
        if (item.mode == dmc_pkg::KIND_WRITE)
        begin
            case (item.reg_select)
                dmc_pkg::REG_CONTROL:
                begin
                    // loop bit wins over the irq bit
                    if (item.write_data[6])
                        play_mode_now = dmc_pkg::MODE_LOOP;
                    else if (item.write_data[7])
                        play_mode_now = dmc_pkg::MODE_IRQ;
                    else
                        play_mode_now = dmc_pkg::MODE_NORMAL;
                    if (!item.write_data[7])
                        irq_now = 1'b0;
                    timer_period = RATE_PERIODS[item.write_data[3:0]];
                end
                dmc_pkg::REG_LEVEL:
                begin
                    level6        = item.write_data[6:1];
                    level_lsb_bit = item.write_data[0];
                    level_out     = item.write_data[6:0];
                end
                dmc_pkg::REG_START:
                begin
                    start_addr = dmc_pkg::START_BASE | {2'b00, item.write_data, 6'b000000};
                    next_addr  = start_addr;
                end
                dmc_pkg::REG_LENGTH:
                begin
                    length_bytes   = {item.write_data, 4'b0000} + 12'd1;
                    bytes_left_now = length_bytes;
                end
                dmc_pkg::REG_ENABLE:
                begin
                    // enable restarts from the start address even mid-sample
                    if (item.write_data[4])
                    begin
                        enabled_now    = 1'b1;
                        next_addr      = start_addr;
                        bytes_left_now = length_bytes;
                    end
                    else
                    begin
                        enabled_now    = 1'b0;
                        bytes_left_now = 12'd0;
                    end
                    irq_now = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // one sample bit moves the level, saturating both ways
            if (holding_byte)
            begin
                if (shift_reg[0])
                begin
                    if (level6 < dmc_pkg::LEVEL_MAX)
                        level6 = level6 + 6'd1;
                end
                else if (level6 != 6'd0)
                begin
                    level6 = level6 - 6'd1;
                end
                level_out = enabled_now ? {level6, level_lsb_bit} : 7'd0;
                shift_reg = shift_reg >> 1;
            end
            // byte boundary: reload, loop back, take the next byte
            if (bits_to_go <= 4'd1)
            begin
                holding_byte = 1'b0;
                bits_to_go   = dmc_pkg::BITS_PER_BYTE;
                if (bytes_left_now == 12'd0 && play_mode_now == dmc_pkg::MODE_LOOP)
                begin
                    next_addr      = start_addr;
                    bytes_left_now = length_bytes;
                end
                if (bytes_left_now != 12'd0)
                begin
                    shift_reg      = item.fetch_data;
                    bytes_left_now = bytes_left_now - 12'd1;
                    next_addr      = (next_addr == dmc_pkg::ADDR_MAX)
                                     ? dmc_pkg::WRAP_ADDR : next_addr + 16'd1;
                    holding_byte   = 1'b1;
                    took           = 1'b1;
                    if (bytes_left_now == 12'd0 && play_mode_now == dmc_pkg::MODE_IRQ)
                        irq_now = 1'b1;
                end
            end
            else
            begin
                bits_to_go = bits_to_go - 4'd1;
            end
        end
        r.sample_value    = level_out;
        r.irq_flag        = irq_now;
        r.fetch_address   = next_addr;
        r.byte_taken      = took;
        r.rate_period     = timer_period;
        r.bytes_remaining = bytes_left_now;
        return r;
    endfunction

    // watch both channels: compare result transfers, predict input transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        dmc_pkg::result_t  seen;
        dmc_pkg::result_t  want;
        dmc_pkg::in_item_t item;
        if (!rst_n)
        begin
            holding_byte   = 1'b0;
            play_mode_now  = dmc_pkg::MODE_NORMAL;
            timer_period   = 12'd0;
            bits_to_go     = 4'd0;
            level6         = 6'd0;
            level_lsb_bit  = 1'b0;
            shift_reg      = 8'd0;
            start_addr     = 16'd0;
            next_addr      = 16'd0;
            length_bytes   = 12'd0;
            bytes_left_now = 12'd0;
            irq_now        = 1'b0;
            enabled_now    = 1'b0;
            level_out      = 7'd0;
            expected_results.delete();
            outstanding    = 0;
        end
        else
        begin
            // result transfer against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.sample_value    = m_axis_tdata[6:0];
                seen.irq_flag        = m_axis_tdata[7];
                seen.fetch_address   = m_axis_tdata[23:8];
                seen.byte_taken      = m_axis_tdata[24];
                seen.rate_period     = m_axis_tdata[36:25];
                seen.bytes_remaining = m_axis_tdata[48:37];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with none expected, fetch_address",
                                    seen.fetch_address, 16'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.sample_value !== want.sample_value)
                        report_mismatch("sample_value", 16'(seen.sample_value),
                                        16'(want.sample_value));
                    if (seen.irq_flag !== want.irq_flag)
                        report_mismatch("irq_flag", 16'(seen.irq_flag), 16'(want.irq_flag));
                    if (seen.fetch_address !== want.fetch_address)
                        report_mismatch("fetch_address", seen.fetch_address,
                                        want.fetch_address);
                    if (seen.byte_taken !== want.byte_taken)
                        report_mismatch("byte_taken", 16'(seen.byte_taken),
                                        16'(want.byte_taken));
                    if (seen.rate_period !== want.rate_period)
                        report_mismatch("rate_period", 16'(seen.rate_period),
                                        16'(want.rate_period));
                    if (seen.bytes_remaining !== want.bytes_remaining)
                        report_mismatch("bytes_remaining", 16'(seen.bytes_remaining),
                                        16'(want.bytes_remaining));
                end
            end
            // input transfer: work out what it must produce
            if (s_axis_tvalid && s_axis_tready)
            begin
                item.mode       = s_axis_tuser;
                item.reg_select = s_axis_tdata[2:0];
                item.write_data = s_axis_tdata[10:3];
                item.fetch_data = s_axis_tdata[18:11];
                expected_results.push_back(predict_step(item));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/delta_modulation_sample_channel_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus, idling and verdict for the sample channel
module delta_modulation_sample_channel_core_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WRAP_TICKS     = 600;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dmc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dmc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int outstanding;
    int send_idle_pct = 32;
    int recv_idle_pct = 79;
    int phase         = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    bit holdoff_done  = 1'b0;

    delta_modulation_sample_channel_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    delta_modulation_sample_channel_core_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // clock and a single reset at the start
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("delta_modulation_sample_channel_core: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, with one long hold-off when the last phase begins
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == 2 && !holdoff_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item, idling first at random, and return at its transfer
    task automatic send_item(input logic kind, input logic [2:0] sel,
                             input logic [7:0] wdata, input logic [7:0] fdata);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b00000, fdata, wdata, sel};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!(kind == dmc_pkg::KIND_WRITE && sel > dmc_pkg::REG_ENABLE))
            items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [7:0] data);
        send_item(dmc_pkg::KIND_WRITE, sel, data, 8'($urandom));
    endtask

    task automatic rate_tick(input logic [7:0] fdata);
        send_item(dmc_pkg::KIND_TICK, 3'($urandom), 8'($urandom), fdata);
    endtask

    // program the channel, then play it out with random sample bytes and, outside the wrap run, some noise
    task automatic play_sequence(input bit wrap_run);
        logic [7:0] ctl;
        logic [7:0] start_b;
        logic [7:0] len_b;
        logic [7:0] en_b;
        int         n_ticks;
        if (wrap_run)
        begin
            // start near the top so the address runs past 0xffff in loop mode
            ctl     = 8'h40 | 8'($urandom_range(15));
            start_b = 8'hFF;
            len_b   = 8'h04;
            en_b    = 8'($urandom) | 8'h10;
            n_ticks = WRAP_TICKS;
        end
        else
        begin
            ctl     = 8'($urandom);
            start_b = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
            len_b   = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            en_b    = ($urandom_range(7) == 0) ? (8'($urandom) & 8'hEF)
                                               : (8'($urandom) | 8'h10);
            n_ticks = $urandom_range(160, 20);
        end
        write_reg(dmc_pkg::REG_CONTROL, ctl);
        if ($urandom_range(2) == 0)
            write_reg(dmc_pkg::REG_LEVEL, 8'($urandom));
        if (wrap_run || $urandom_range(9) != 0)
            write_reg(dmc_pkg::REG_START, start_b);
        if (wrap_run || $urandom_range(9) != 0)
            write_reg(dmc_pkg::REG_LENGTH, len_b);
        write_reg(dmc_pkg::REG_ENABLE, en_b);
        repeat (n_ticks)
        begin
            if (!wrap_run && $urandom_range(24) == 0)
                write_reg(3'($urandom), 8'($urandom));
            else
                rate_tick(8'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= dmc_pkg::KIND_TICK;
        s_axis_tdata  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // first tick after reset: counter already expired, nothing to take
        rate_tick(8'hA5);
        // both mode bits set, then irq enable clear
        write_reg(dmc_pkg::REG_CONTROL, 8'hCF);
        write_reg(dmc_pkg::REG_CONTROL, 8'h00);
        write_reg(dmc_pkg::REG_LEVEL, 8'hFF);
        write_reg(dmc_pkg::REG_LEVEL, 8'h00);
        write_reg(dmc_pkg::REG_START, 8'hFF);
        write_reg(dmc_pkg::REG_LENGTH, 8'h00);
        // irq mode with a single byte sample
        write_reg(dmc_pkg::REG_CONTROL, 8'h87);
        write_reg(dmc_pkg::REG_ENABLE, 8'h10);
        rate_tick(8'hFF);
        rate_tick(8'h00);
        write_reg(dmc_pkg::REG_CONTROL, 8'h07);
        // restart with bytes still left
        write_reg(dmc_pkg::REG_LENGTH, 8'hFF);
        write_reg(dmc_pkg::REG_ENABLE, 8'hFF);
        rate_tick(8'h00);
        // disable, then a tick with no byte held: level and output stay as they are
        write_reg(dmc_pkg::REG_ENABLE, 8'hEF);
        rate_tick(8'h5A);
        // unused selects
        write_reg(3'd5, 8'hFF);
        write_reg(3'd6, 8'h00);
        write_reg(3'd7, 8'hAA);
        write_reg(dmc_pkg::REG_START, 8'h00);
        write_reg(dmc_pkg::REG_LEVEL, 8'h7E);
        rate_tick(8'h3C);
        write_reg(dmc_pkg::REG_CONTROL, 8'h40);
        rate_tick(8'hC3);

        // sender idles less than the receiver
        play_sequence(1'b1);
        while (items_sent < 700)
            play_sequence(1'b0);

        // the other way round
        send_idle_pct = 79;
        recv_idle_pct = 32;
        while (items_sent < 1400)
            play_sequence(1'b0);

        // no idling, after the receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
        while (items_sent < 2100)
            play_sequence(1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("delta_modulation_sample_channel_core: match");
        else
            $display("delta_modulation_sample_channel_core: mismatch");
        $finish;
    end

endmodule
